[hdl/wjr_pkg.sv]
package wjr_pkg;

    localparam int C_WORD_BITS      = 24;
    localparam int C_FRAC_BITS      = 16;
    localparam int C_IDX_BITS       = 5;
    localparam int C_JOINTS_WIDE    = 22;
    localparam int C_JOINTS_NARROW  = 21;
    localparam int C_CORDIC_STEPS   = 28;
    localparam int C_PADDR_BITS     = 3;
    localparam int C_PDATA_BITS     = 32;

    localparam longint C_PI_Q32          = 64'd13493037705;
    localparam longint C_HALF_PI_Q30     = 64'd1686629713;
    localparam longint C_CORDIC_GAIN_Q30 = 64'd652032874;

    localparam logic C_REG_SKELETON = 1'b0;

    typedef enum logic {
        OP_HEADER = 1'b0,
        OP_JOINT  = 1'b1
    } t_op;

    typedef struct packed {
        t_op                            op;
        logic signed [C_WORD_BITS-1:0]  yaw_rate;
        logic signed [C_WORD_BITS-1:0]  vel_x;
        logic signed [C_WORD_BITS-1:0]  vel_z;
        logic signed [C_WORD_BITS-1:0]  root_height;
        logic signed [C_WORD_BITS-1:0]  local_x;
        logic signed [C_WORD_BITS-1:0]  local_y;
        logic signed [C_WORD_BITS-1:0]  local_z;
    } t_in_word;

    typedef struct packed {
        logic signed [C_WORD_BITS-1:0]  pos_x;
        logic signed [C_WORD_BITS-1:0]  pos_y;
        logic signed [C_WORD_BITS-1:0]  pos_z;
        logic [C_IDX_BITS-1:0]          joint_index;
        logic                           frame_done;
        logic                           malformed;
    } t_out_word;

    typedef struct packed {
        logic       valid;
        logic       is_header;
        t_in_word   word;
    } t_q_head;

    // Arctangent of 2^-i in Q6.30; past the table the angle equals the shift.
    function automatic logic signed [35:0] cordic_atan(input logic [4:0] i);
        logic signed [35:0] a;
        case (i)
            5'd0: a = 36'sd843314857;
            5'd1: a = 36'sd497837829;
            5'd2: a = 36'sd263043837;
            5'd3: a = 36'sd133525159;
            5'd4: a = 36'sd67021687;
            5'd5: a = 36'sd33543516;
            5'd6: a = 36'sd16775851;
            5'd7: a = 36'sd8388437;
            5'd8: a = 36'sd4194283;
            5'd9: a = 36'sd2097149;
            default: a = 36'sd1 <<< (5'd30 - i);
        endcase
        return a;
    endfunction

endpackage

[hdl/world_joint_recovery.sv]
// World joint recovery: turns a stream of motion frames into world positions.
// Input channel (i_in_valid / o_in_stall / i_in_word): a header word opens a
// frame with yaw rate, velocity and root height; joint words follow, one per
// joint. Output channel (o_out_valid / i_out_stall / o_out_word): exactly one
// word per input word, in order: the root for a header, else the world joint.
// A two-entry queue takes input words while the execution side is busy.
// A joint word passes from queue head to output register through states
// J1, J2, J3 and EMIT, with two passes through the shared pair of multipliers.
// A header goes through a remainder modulo pi by reciprocal multiplication,
// a 28-step CORDIC, and four multiplier passes for the double angle and the
// velocity rotation. One word is worked at a time.
// While the receiver stalls, the result holds in the output register; one
// further word can be finished before the block stops taking the queue.
// Reset (synchronous, active low) clears the yaw, root position and frame
// state, sets cos to one, and selects the 22-joint skeleton.
// Register skeleton at byte address 0 on the APB port: 0 = 22 joints, 1 = 21.
module world_joint_recovery #(
    parameter int FRAC_BITS = wjr_pkg::C_FRAC_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  wjr_pkg::t_in_word                   i_in_word,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output wjr_pkg::t_out_word                  o_out_word,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [wjr_pkg::C_PADDR_BITS-1:0]    paddr,
    input  logic [wjr_pkg::C_PDATA_BITS-1:0]    pwdata,
    output logic [wjr_pkg::C_PDATA_BITS-1:0]    prdata,
    output logic                                pready
);
    import wjr_pkg::*;

    logic    r_skeleton;
    t_q_head head;
    logic    pop;

    assign pready = 1'b1;
    assign prdata = (paddr[C_PADDR_BITS-1] == C_REG_SKELETON)
                    ? C_PDATA_BITS'(r_skeleton) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skeleton <= 1'b0;
        end else if (psel && penable && pwrite && pready
                     && paddr[C_PADDR_BITS-1] == C_REG_SKELETON) begin
            r_skeleton <= pwdata[0];
        end
    end

    wjr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .o_head     (head),
        .i_pop      (pop)
    );

    wjr_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_skeleton  (r_skeleton),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule

[hdl/wjr_front.sv]
module wjr_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  wjr_pkg::t_in_word i_in_word,
    output wjr_pkg::t_q_head  o_head,
    input  logic              i_pop
);
    import wjr_pkg::*;

    t_in_word   r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_in_stall = (r_cnt == 2'd2);
    assign push = i_in_valid && !o_in_stall;
    assign pop  = i_pop && (r_cnt != 2'd0);

    assign o_head.valid     = (r_cnt != 2'd0);
    assign o_head.is_header = (r_q[r_rp].op == OP_HEADER);
    assign o_head.word      = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_in_word;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

endmodule

[hdl/wjr_back.sv]
module wjr_back #(
    parameter int FRAC_BITS = wjr_pkg::C_FRAC_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_skeleton,
    input  wjr_pkg::t_q_head   i_head,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output wjr_pkg::t_out_word o_out_word
);
    import wjr_pkg::*;

    localparam int W  = C_WORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int RB = F + 3;
    localparam int SB = ((F + 3 > W) ? F + 3 : W) + 1;
    localparam longint PI_Q_L = (C_PI_Q32 + (64'd1 << (31 - F))) >> (32 - F);
    localparam logic [RB:0] PI_Q = (RB+1)'(PI_Q_L);
    localparam longint RECIP_L = (longint'(1) << SB) / PI_Q_L;
    localparam logic [SB-1:0] RECIP = SB'(RECIP_L);
    localparam logic signed [69:0] MAXW = (70'sd1 <<< (W - 1)) - 70'sd1;
    localparam logic signed [69:0] MINW = -(70'sd1 <<< (W - 1));

    typedef enum logic [3:0] {
        S_IDLE, S_MOD, S_MOD2, S_CINIT, S_CORD, S_DA1, S_DA2, S_DA3,
        S_V1, S_V2, S_V3, S_J1, S_J2, S_J3, S_EMIT
    } t_state;

    t_state                 r_state;
    t_in_word               r_word;
    t_out_word              r_res;
    logic [RB-1:0]          r_yaw;
    logic signed [W-1:0]    r_rate, r_vx, r_vz;
    logic signed [W-1:0]    r_root_x, r_root_y, r_root_z;
    logic signed [W-1:0]    r_cos, r_sin;
    logic [C_IDX_BITS-1:0]  r_count;
    logic                   r_open;
    logic signed [SB-1:0]   r_sum;
    logic [SB-1:0]          r_quo;
    logic [RB-1:0]          r_rem;
    logic [4:0]             r_step;
    logic signed [33:0]     r_x, r_y;
    logic signed [35:0]     r_z;
    logic signed [67:0]     r_p0, r_p1;

    logic [SB-1:0]          mag;
    logic [2*SB-1:0]        quo_prod;
    logic [SB-1:0]          part;
    logic [RB-1:0]          n_rem;
    logic [RB-1:0]          yaw_fix;
    logic signed [33:0]     ma0, mb0, ma1, mb1;
    logic signed [69:0]     diff, summ;
    logic [C_IDX_BITS-1:0]  joints;
    logic                   bad, out_free;
    t_out_word              bad_res;

    function automatic logic signed [69:0] rnd_f(input logic signed [69:0] v);
        return (v + (70'sd1 <<< (F - 1))) >>> F;
    endfunction

    function automatic logic signed [69:0] rnd_60(input logic signed [69:0] v);
        return (v + (70'sd1 <<< (59 - F))) >>> (60 - F);
    endfunction

    function automatic logic signed [W-1:0] sat_w(input logic signed [69:0] v);
        logic signed [69:0] t;
        t = (v > MAXW) ? MAXW : ((v < MINW) ? MINW : v);
        return t[W-1:0];
    endfunction

    assign joints   = i_skeleton ? C_IDX_BITS'(C_JOINTS_NARROW) : C_IDX_BITS'(C_JOINTS_WIDE);
    assign bad      = !r_open || (r_count >= joints);
    assign out_free = !o_out_valid || !i_out_stall;
    assign o_pop    = (r_state == S_IDLE) && i_head.valid;

    // Remainder modulo pi: the reciprocal product gives the quotient or one
    // less, so a single compare and subtract finishes it.
    assign mag      = r_sum[SB-1] ? SB'(-r_sum) : SB'(r_sum);
    assign quo_prod = (2*SB)'(mag) * (2*SB)'(RECIP);
    assign part     = mag - r_quo * SB'(PI_Q);
    assign n_rem    = (part >= SB'(PI_Q)) ? RB'(part - SB'(PI_Q)) : RB'(part);
    assign yaw_fix  = (r_sum[SB-1] && (r_rem != '0)) ? RB'(PI_Q - (RB+1)'(r_rem)) : r_rem;

    always_comb begin
        bad_res           = '0;
        bad_res.malformed = 1'b1;
    end

    // The two multipliers are shared by the double angle and both rotations.
    always_comb begin
        ma0 = 34'(r_word.local_x);
        mb0 = 34'(r_cos);
        ma1 = 34'(r_word.local_z);
        mb1 = 34'(r_sin);
        case (r_state)
            S_DA1: begin
                ma0 = -r_y; mb0 = -r_y; ma1 = r_x; mb1 = r_x;
            end
            S_DA2: begin
                ma0 = r_x; mb0 = -r_y; ma1 = r_x; mb1 = r_x;
            end
            S_V1: begin
                ma0 = 34'(r_vx); mb0 = 34'(r_cos); ma1 = 34'(r_vz); mb1 = 34'(r_sin);
            end
            S_V2: begin
                ma0 = 34'(r_vx); mb0 = 34'(r_sin); ma1 = 34'(r_vz); mb1 = 34'(r_cos);
            end
            S_J2: begin
                ma0 = 34'(r_word.local_x); mb0 = 34'(r_sin);
                ma1 = 34'(r_word.local_z); mb1 = 34'(r_cos);
            end
            default: begin
                ma0 = 34'(r_word.local_x); mb0 = 34'(r_cos);
                ma1 = 34'(r_word.local_z); mb1 = 34'(r_sin);
            end
        endcase
    end

    assign diff = 70'(r_p0) - 70'(r_p1);
    assign summ = 70'(r_p0) + 70'(r_p1);

    always_ff @(posedge i_clk) begin
        r_p0 <= ma0 * mb0;
        r_p1 <= ma1 * mb1;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            o_out_valid <= 1'b0;
            r_yaw       <= '0;
            r_rate      <= '0;
            r_vx        <= '0;
            r_vz        <= '0;
            r_root_x    <= '0;
            r_root_y    <= '0;
            r_root_z    <= '0;
            r_cos       <= sat_w(70'sd1 <<< F);
            r_sin       <= '0;
            r_count     <= '0;
            r_open      <= 1'b0;
        end else begin
            if ((r_state == S_EMIT) && out_free) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_head.valid) begin
                        r_word <= i_head.word;
                        if (i_head.is_header) begin
                            r_res   <= '0;
                            r_sum   <= SB'(r_yaw) + SB'(r_rate);
                            r_state <= S_MOD;
                        end else if (bad) begin
                            r_res   <= bad_res;
                            r_state <= S_EMIT;
                        end else begin
                            r_res   <= '0;
                            r_state <= S_J1;
                        end
                    end
                end
                S_MOD: begin
                    r_quo   <= quo_prod[2*SB-1:SB];
                    r_state <= S_MOD2;
                end
                S_MOD2: begin
                    r_rem   <= n_rem;
                    r_state <= S_CINIT;
                end
                S_CINIT: begin
                    r_yaw   <= yaw_fix;
                    r_x     <= 34'(C_CORDIC_GAIN_Q30);
                    r_y     <= '0;
                    r_z     <= (36'(yaw_fix) <<< (30 - F)) - 36'(C_HALF_PI_Q30);
                    r_step  <= '0;
                    r_state <= S_CORD;
                end
                S_CORD: begin
                    if (!r_z[35]) begin
                        r_x <= r_x - (r_y >>> r_step);
                        r_y <= r_y + (r_x >>> r_step);
                        r_z <= r_z - cordic_atan(r_step);
                    end else begin
                        r_x <= r_x + (r_y >>> r_step);
                        r_y <= r_y - (r_x >>> r_step);
                        r_z <= r_z + cordic_atan(r_step);
                    end
                    r_step <= r_step + 5'd1;
                    if (r_step == 5'(C_CORDIC_STEPS - 1)) begin
                        r_state <= S_DA1;
                    end
                end
                S_DA1: r_state <= S_DA2;
                S_DA2: begin
                    r_cos   <= sat_w(rnd_60(diff));
                    r_state <= S_DA3;
                end
                S_DA3: begin
                    r_sin   <= sat_w(rnd_60(70'(r_p0) <<< 1));
                    r_state <= S_V1;
                end
                S_V1: r_state <= S_V2;
                S_V2: begin
                    r_root_x <= sat_w(rnd_f(diff) + 70'(r_root_x));
                    r_state  <= S_V3;
                end
                S_V3: begin
                    r_root_z        <= sat_w(rnd_f(summ) + 70'(r_root_z));
                    r_root_y        <= r_word.root_height;
                    r_rate          <= r_word.yaw_rate;
                    r_vx            <= r_word.vel_x;
                    r_vz            <= r_word.vel_z;
                    r_count         <= C_IDX_BITS'(1);
                    r_open          <= 1'b1;
                    r_res.pos_x     <= r_root_x;
                    r_res.pos_y     <= r_word.root_height;
                    r_res.pos_z     <= sat_w(rnd_f(summ) + 70'(r_root_z));
                    r_state         <= S_EMIT;
                end
                S_J1: r_state <= S_J2;
                S_J2: begin
                    r_res.pos_x <= sat_w(rnd_f(diff) + 70'(r_root_x));
                    r_state     <= S_J3;
                end
                S_J3: begin
                    r_res.pos_y       <= r_word.local_y;
                    r_res.pos_z       <= sat_w(rnd_f(summ) + 70'(r_root_z));
                    r_res.joint_index <= r_count;
                    r_count           <= r_count + C_IDX_BITS'(1);
                    if (r_count + C_IDX_BITS'(1) >= joints) begin
                        r_res.frame_done <= 1'b1;
                        r_open           <= 1'b0;
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        o_out_word  <= r_res;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

[hdl/wjr_checker.sv]
module wjr_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input wjr_pkg::t_out_word o_out_word
);
    import wjr_pkg::*;

    // A held result may not vanish while the receiver stalls.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output word dropped under stall");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // A rejected joint carries no position and closes no frame.
    a_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.malformed |->
            o_out_word.pos_x == '0 && o_out_word.pos_y == '0
            && o_out_word.pos_z == '0 && o_out_word.joint_index == '0
            && !o_out_word.frame_done)
        else $error("malformed word with payload");

    // Only the last joint of either skeleton ends a frame.
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.frame_done |->
            !o_out_word.malformed
            && (o_out_word.joint_index == C_IDX_BITS'(C_JOINTS_WIDE - 1)
                || o_out_word.joint_index == C_IDX_BITS'(C_JOINTS_NARROW - 1)))
        else $error("frame end on wrong joint");

endmodule

bind world_joint_recovery wjr_checker u_wjr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);

[verif/testbench.sv]
module testbench;
    import wjr_pkg::*;

    localparam int    WATCHDOG_LIMIT = 20000;
    localparam int    SETTLE_CYCLES  = 100;
    localparam longint WMAX = (longint'(1) <<< (C_WORD_BITS - 1)) - 1;
    localparam longint WMIN = -WMAX - 1;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_stall;
    t_in_word                 i_in_word;
    logic                     o_out_valid;
    logic                     i_out_stall;
    t_out_word                o_out_word;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [C_PADDR_BITS-1:0]  paddr;
    logic [C_PDATA_BITS-1:0]  pwdata;
    logic [C_PDATA_BITS-1:0]  prdata;
    logic                     pready;

    world_joint_recovery dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // Predictor state.
    logic    narrow_skel;
    longint  yaw;
    longint  next_rate;
    longint  next_vx;
    longint  next_vz;
    longint  root_x;
    longint  root_y;
    longint  root_z;
    longint  cos_t;
    longint  sin_t;
    int      joint_num;
    logic    in_frame;

    t_out_word positions_due[$];
    int  send_gap_pct;
    int  stall_pct;
    int  error_count;
    int  idle_cycles;
    int  n_headers;
    int  n_joints;
    int  n_rejected;
    int  n_frames;
    int  n_checked;

    longint atan_steps[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                              33543516, 16775851, 8388437, 4194283, 2097149};

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic longint clamp_word(longint v);
        if (v > WMAX) return WMAX;
        if (v < WMIN) return WMIN;
        return v;
    endfunction

    function automatic longint round_q(longint p);
        return (p + (longint'(1) <<< (C_FRAC_BITS - 1))) >>> C_FRAC_BITS;
    endfunction

    // Sine and cosine of the yaw by CORDIC, then the double angle.
    function automatic void refresh_rotation();
        longint x, y, z, nx, a, c, s;
        x = C_CORDIC_GAIN_Q30;
        y = 0;
        z = yaw * (longint'(1) <<< (30 - C_FRAC_BITS)) - C_HALF_PI_Q30;
        for (int i = 0; i < C_CORDIC_STEPS; i++) begin
            a = (i < 10) ? atan_steps[i] : (longint'(1) <<< (30 - i));
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - a;
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + a;
            end
            x = nx;
        end
        c = -y;
        s = x;
        cos_t = clamp_word((c * c - s * s + (longint'(1) <<< (59 - C_FRAC_BITS)))
                           >>> (60 - C_FRAC_BITS));
        sin_t = clamp_word((2 * s * c + (longint'(1) <<< (59 - C_FRAC_BITS)))
                           >>> (60 - C_FRAC_BITS));
    endfunction

    function automatic t_out_word predict_position(t_in_word w);
        t_out_word r;
        longint    pi_fix, sum, vx, vz, lx, lz;
        int        joints;
        r = '0;
        if (w.op == OP_HEADER) begin
            pi_fix = (C_PI_Q32 + (longint'(1) <<< (31 - C_FRAC_BITS))) >>> (32 - C_FRAC_BITS);
            sum = (yaw + next_rate) % pi_fix;
            if (sum < 0) sum += pi_fix;
            yaw = sum;
            refresh_rotation();
            vx = round_q(next_vx * cos_t - next_vz * sin_t);
            vz = round_q(next_vx * sin_t + next_vz * cos_t);
            root_x = clamp_word(root_x + vx);
            root_z = clamp_word(root_z + vz);
            root_y = longint'(w.root_height);
            next_rate = longint'(w.yaw_rate);
            next_vx = longint'(w.vel_x);
            next_vz = longint'(w.vel_z);
            joint_num = 1;
            in_frame = 1'b1;
            r.pos_x = root_x[C_WORD_BITS-1:0];
            r.pos_y = root_y[C_WORD_BITS-1:0];
            r.pos_z = root_z[C_WORD_BITS-1:0];
            n_headers++;
        end else begin
            joints = narrow_skel ? C_JOINTS_NARROW : C_JOINTS_WIDE;
            if (!in_frame || joint_num >= joints) begin
                r.malformed = 1'b1;
                n_rejected++;
            end else begin
                lx = longint'(w.local_x);
                lz = longint'(w.local_z);
                vx = clamp_word(round_q(lx * cos_t - lz * sin_t) + root_x);
                vz = clamp_word(round_q(lx * sin_t + lz * cos_t) + root_z);
                r.pos_x = vx[C_WORD_BITS-1:0];
                r.pos_y = w.local_y;
                r.pos_z = vz[C_WORD_BITS-1:0];
                r.joint_index = joint_num[C_IDX_BITS-1:0];
                joint_num++;
                if (joint_num >= joints) begin
                    r.frame_done = 1'b1;
                    in_frame = 1'b0;
                    n_frames++;
                end
                n_joints++;
            end
        end
        return r;
    endfunction

    function automatic logic [C_WORD_BITS-1:0] pick_value();
        case ($urandom_range(0, 5))
            0: return {1'b0, {(C_WORD_BITS-1){1'b1}}};
            1: return {1'b1, {(C_WORD_BITS-1){1'b0}}};
            2: return '0;
            3: return C_WORD_BITS'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
            default: return C_WORD_BITS'($urandom);
        endcase
    endfunction

    function automatic t_in_word make_word(t_op op);
        t_in_word w;
        w.op          = op;
        w.yaw_rate    = pick_value();
        w.vel_x       = pick_value();
        w.vel_z       = pick_value();
        w.root_height = pick_value();
        w.local_x     = pick_value();
        w.local_y     = pick_value();
        w.local_z     = pick_value();
        return w;
    endfunction

    // Sends one word; valid stays high unless the next word is held back.
    task automatic send_word(t_in_word w);
        int        gap;
        t_out_word due;
        gap = ($urandom_range(0, 99) < send_gap_pct) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
        due = predict_position(w);
        positions_due.insert(positions_due.size(), due);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (positions_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_skeleton(logic v);
        drain();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= C_PADDR_BITS'(C_REG_SKELETON) << 2;
        pwdata  <= C_PDATA_BITS'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        narrow_skel = v;
    endtask

    task automatic test_directed();
        t_in_word w;
        send_word(make_word(OP_JOINT));
        w = '0;
        w.op = OP_HEADER;
        w.yaw_rate = {1'b0, {(C_WORD_BITS-1){1'b1}}};
        w.vel_x = {1'b0, {(C_WORD_BITS-1){1'b1}}};
        w.vel_z = {1'b1, {(C_WORD_BITS-1){1'b0}}};
        w.root_height = {1'b1, {(C_WORD_BITS-1){1'b0}}};
        send_word(w);
        w = '1;
        w.op = OP_JOINT;
        send_word(w);
        w.local_x = {1'b0, {(C_WORD_BITS-1){1'b1}}};
        w.local_y = {1'b1, {(C_WORD_BITS-1){1'b0}}};
        w.local_z = {1'b0, {(C_WORD_BITS-1){1'b1}}};
        send_word(w);
        // A new header drops the open frame and applies the full-scale velocity of the header before it.
        w = '0;
        w.op = OP_HEADER;
        w.yaw_rate = {1'b1, {(C_WORD_BITS-1){1'b0}}};
        send_word(w);
        send_word(w);
        w = '0;
        w.op = OP_JOINT;
        send_word(w);
        for (int i = 0; i < 8; i++) send_word(make_word(i[0] ? OP_JOINT : OP_HEADER));
    endtask

    // Mostly complete frames, some short and some with joints past the end.
    task automatic test_frames(int count, int gap_pct, int stall_p);
        int joints, n, sent;
        send_gap_pct = gap_pct;
        stall_pct = stall_p;
        sent = 0;
        while (sent < count) begin
            joints = (narrow_skel ? C_JOINTS_NARROW : C_JOINTS_WIDE) - 1;
            case ($urandom_range(0, 9))
                7:       n = $urandom_range(0, joints - 1);
                8, 9:    n = joints + $urandom_range(1, 3);
                default: n = joints;
            endcase
            send_word(make_word(OP_HEADER));
            for (int j = 0; j < n; j++) send_word(make_word(OP_JOINT));
            sent += n + 1;
        end
    endtask

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge i_clk) begin
        t_out_word e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (positions_due.size() == 0) begin
                $display("%0t: unexpected word %h", $time, o_out_word);
                error_count++;
            end else begin
                e = positions_due.pop_front();
                n_checked++;
                if (o_out_word.pos_x !== e.pos_x) begin
                    $display("%0t: pos_x expected %h actual %h", $time, e.pos_x,
                             o_out_word.pos_x);
                    error_count++;
                end
                if (o_out_word.pos_y !== e.pos_y) begin
                    $display("%0t: pos_y expected %h actual %h", $time, e.pos_y,
                             o_out_word.pos_y);
                    error_count++;
                end
                if (o_out_word.pos_z !== e.pos_z) begin
                    $display("%0t: pos_z expected %h actual %h", $time, e.pos_z,
                             o_out_word.pos_z);
                    error_count++;
                end
                if (o_out_word.joint_index !== e.joint_index) begin
                    $display("%0t: joint_index expected %0d actual %0d", $time,
                             e.joint_index, o_out_word.joint_index);
                    error_count++;
                end
                if (o_out_word.frame_done !== e.frame_done) begin
                    $display("%0t: frame_done expected %b actual %b", $time,
                             e.frame_done, o_out_word.frame_done);
                    error_count++;
                end
                if (o_out_word.malformed !== e.malformed) begin
                    $display("%0t: malformed expected %b actual %b", $time,
                             e.malformed, o_out_word.malformed);
                    error_count++;
                end
            end
        end
    end

    // Counts cycles in which neither channel moves a word.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_word = '0;
        i_out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        send_gap_pct = 0;
        stall_pct = 0;
        error_count = 0;
        idle_cycles = 0;
        n_headers = 0;
        n_joints = 0;
        n_rejected = 0;
        n_frames = 0;
        n_checked = 0;
        narrow_skel = 1'b0;
        yaw = 0;
        next_rate = 0;
        next_vx = 0;
        next_vz = 0;
        root_x = 0;
        root_y = 0;
        root_z = 0;
        cos_t = longint'(1) <<< C_FRAC_BITS;
        sin_t = 0;
        joint_num = 0;
        in_frame = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_skeleton(1'b0);
        test_directed();
        test_frames(175, 0, 0);
        write_skeleton(1'b1);
        test_frames(175, 55, 0);
        write_skeleton(1'b0);
        test_frames(175, 0, 55);
        write_skeleton(1'b1);
        test_frames(175, 30, 30);
        drain();

        $display("Checked %0d words: %0d headers, %0d joints, %0d rejected joints,",
                 n_checked, n_headers, n_joints, n_rejected);
        $display("%0d complete frames over both skeletons and four idling mixes.", n_frames);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
